/* src/rgbmtx_pkg.sv */
// Package for the RGB LED matrix scanner: field widths, command codes and register indexes.
`default_nettype none

package rgbmtx_pkg;

  // Matrix geometry
  localparam int unsigned NumCols   = 8;
  localparam int unsigned NumRows   = 8;
  localparam int unsigned ColW      = 3;
  localparam int unsigned RowW      = 3;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned DurW      = 16;

  // Configuration port
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam logic [CfgIdxW-1:0] CfgPhaseLimit    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSoundAllowed  = 2'd1;
  localparam logic [LevelW-1:0]  PhaseLimitRst    = 8'd15;
  localparam logic               SoundAllowedRst  = 1'b1;

  // Stream widths
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned CmdW      = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK       = 3'd0,
    CMD_WRITE_PIX  = 3'd1,
    CMD_SET_AUX    = 3'd2,
    CMD_START_TONE = 3'd3,
    CMD_STOP_TONE  = 3'd4
  } cmd_e;

  // One row beat for the shift chain, lowest field in the lowest bits
  typedef struct packed {
    logic              tone_on;
    logic [ColW-1:0]   active_column;
    logic [LevelW-1:0] blue_bits;
    logic [LevelW-1:0] green_bits;
    logic [LevelW-1:0] red_bits;
    logic [LevelW-1:0] aux_byte;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

/* src/rgb_led_matrix_pwm_scanner.sv */
// Top level of the RGB LED matrix scanner: frame store, PWM phase, column scan and tone timer.
//
// Usage:
//   Commands arrive on the s_axis channel, the command code in tuser and its operands in
//   tdata. A tick advances the brightness phase and, at the configured limit, steps the
//   scan column and the tone countdown; it then yields one beat on m_axis carrying the aux
//   byte (phase 0, column 0 only), the red, green and blue row bits of the active column,
//   the column number and the sound state. All other commands give no output beat.
//   Registers (phase_limit, sound_allowed) are written through the cfg channel, which
//   is always ready; write them only while the block is idle.
//   A tick result is registered into the output slot, or into the skid slot behind a waiting one.
//   Throughput: one command per cycle while s_axis_tready is high; phase, column, tone and
//   the 24 level compares update in one pass from the state registers into the result slot.
//   Stalls: an output register plus a skid register sit before m_axis, so a command is
//   still taken while one result waits; s_axis_tready drops only with both slots full.
//   Reset: the frame store (held in flip-flops) clears to black at once, phase, column,
//   aux LEDs and tone state clear, and the registers return to 15 and 1.
`default_nettype none

module rgb_led_matrix_pwm_scanner (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Command stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: pixel_column[2:0], pixel_row[5:3], red_level[13:6], green_level[21:14],
  //        blue_level[29:22], aux_value[37:30], tone_duration[53:38], zero pad[55:54]
  input  wire logic [rgbmtx_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: command[2:0]
  input  wire logic [rgbmtx_pkg::CmdW-1:0]         s_axis_tuser,
  // Row beat stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: aux_byte[7:0], red_bits[15:8], green_bits[23:16], blue_bits[31:24],
  //        active_column[34:32], tone_on[35], zero pad[39:36]
  output logic [rgbmtx_pkg::OutDataW-1:0]          m_axis_tdata,
  // Configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rgbmtx_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [rgbmtx_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned ColW   = rgbmtx_pkg::ColW;
  localparam int unsigned RowW   = rgbmtx_pkg::RowW;
  localparam int unsigned LevelW = rgbmtx_pkg::LevelW;
  localparam int unsigned DurW   = rgbmtx_pkg::DurW;
  localparam int unsigned NumCols = rgbmtx_pkg::NumCols;
  localparam int unsigned NumRows = rgbmtx_pkg::NumRows;

  // Input fields
  logic [ColW-1:0]   pix_col;
  logic [RowW-1:0]   pix_row;
  logic [LevelW-1:0] red_lvl;
  logic [LevelW-1:0] green_lvl;
  logic [LevelW-1:0] blue_lvl;
  logic [LevelW-1:0] aux_val;
  logic [DurW-1:0]   tone_dur;

  assign pix_col   = s_axis_tdata[2:0];
  assign pix_row   = s_axis_tdata[5:3];
  assign red_lvl   = s_axis_tdata[13:6];
  assign green_lvl = s_axis_tdata[21:14];
  assign blue_lvl  = s_axis_tdata[29:22];
  assign aux_val   = s_axis_tdata[37:30];
  assign tone_dur  = s_axis_tdata[53:38];

  // Frame store: one entry per column, eight row levels per colour
  logic [NumRows-1:0][LevelW-1:0] red_q   [NumCols];
  logic [NumRows-1:0][LevelW-1:0] green_q [NumCols];
  logic [NumRows-1:0][LevelW-1:0] blue_q  [NumCols];

  // Scan and sound state
  logic [LevelW-1:0] phase_q, phase_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [LevelW-1:0] aux_q;
  logic [DurW-1:0]   tone_rem_q, tone_rem_d;
  logic              sound_q, sound_d;
  logic [LevelW-1:0] phase_limit_q;
  logic              sound_allowed_q;

  // Output slot and skid slot
  logic                 out_valid_q, skid_valid_q;
  rgbmtx_pkg::result_t  out_q, skid_q, res;

  logic s_accept, m_accept, is_tick, push, slot_free;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign m_accept  = m_axis_tvalid && m_axis_tready;
  assign is_tick   = (s_axis_tuser == rgbmtx_pkg::CMD_TICK);
  assign push      = s_accept && is_tick;
  assign slot_free = m_accept || !out_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rgbmtx_pkg::OutDataW - rgbmtx_pkg::ResultW){1'b0}}, out_q};
  assign cfg_ready_o   = 1'b1;

  // Tick update: advance phase, wrap into the next column, count the tone down
  logic [LevelW-1:0] phase_inc;
  logic              wrap;

  always_comb begin
    phase_inc  = phase_q + 8'd1;
    wrap       = (phase_inc >= phase_limit_q);
    phase_d    = wrap ? '0 : phase_inc;
    col_d      = wrap ? col_q + 3'd1 : col_q;
    tone_rem_d = tone_rem_q;
    sound_d    = sound_q;
    if (wrap && (tone_rem_q != '0)) begin
      tone_rem_d = tone_rem_q - 16'd1;
      if (tone_rem_q == 16'd1) begin
        sound_d = 1'b0;
      end
    end
  end

  // Result: compare each level of the new column against the new phase
  always_comb begin
    res               = '0;
    res.aux_byte      = ((phase_d == '0) && (col_d == '0)) ? aux_q : '0;
    res.active_column = col_d;
    res.tone_on       = sound_d;
    for (int k = 0; k < NumRows; k++) begin
      res.red_bits[k]   = (red_q[col_d][k]   > phase_d);
      res.green_bits[k] = (green_q[col_d][k] > phase_d);
      res.blue_bits[k]  = (blue_q[col_d][k]  > phase_d);
    end
  end

  // Write pixel levels into the frame store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCols; c++) begin
        red_q[c]   <= '0;
        green_q[c] <= '0;
        blue_q[c]  <= '0;
      end
    end else if (s_accept && (s_axis_tuser == rgbmtx_pkg::CMD_WRITE_PIX)) begin
      red_q[pix_col][pix_row]   <= red_lvl;
      green_q[pix_col][pix_row] <= green_lvl;
      blue_q[pix_col][pix_row]  <= blue_lvl;
    end
  end

  // Hold scan, aux and sound state; apply commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      col_q      <= '0;
      aux_q      <= '0;
      tone_rem_q <= '0;
      sound_q    <= 1'b0;
    end else if (s_accept) begin
      case (s_axis_tuser)
        rgbmtx_pkg::CMD_TICK: begin
          phase_q    <= phase_d;
          col_q      <= col_d;
          tone_rem_q <= tone_rem_d;
          sound_q    <= sound_d;
        end
        rgbmtx_pkg::CMD_SET_AUX: begin
          aux_q <= aux_val;
        end
        rgbmtx_pkg::CMD_START_TONE: begin
          sound_q    <= sound_allowed_q;
          tone_rem_q <= tone_dur;
        end
        rgbmtx_pkg::CMD_STOP_TONE: begin
          sound_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_limit_q   <= rgbmtx_pkg::PhaseLimitRst;
      sound_allowed_q <= rgbmtx_pkg::SoundAllowedRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rgbmtx_pkg::CfgPhaseLimit:   phase_limit_q   <= cfg_data_i;
        rgbmtx_pkg::CfgSoundAllowed: sound_allowed_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Output and skid slots: refill from skid, else take a fresh tick beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // The skid slot is only ever filled behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  // The scan column only ever steps forward by one
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q != $past(col_q)) |-> (col_q == $past(col_q) + 3'd1))
    else $error("scan column jumped");

  // A command that is not a tick leaves the output occupancy alone
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !is_tick && !m_accept) |=>
      (out_valid_q == $past(out_valid_q) && skid_valid_q == $past(skid_valid_q)))
    else $error("non-tick command changed output occupancy");

  // Sound can only switch on through a start tone beat
  a_sound_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sound_q) |-> $past(s_accept && (s_axis_tuser == rgbmtx_pkg::CMD_START_TONE)))
    else $error("sound switched on without start tone");
`endif

endmodule

`default_nettype wire
